/* rtl/rrle_pkg.sv */
// Shared constants, types and the pixel conversion function of the RGBE run-length decoder.
`default_nettype none

package rrle_pkg;

    // Store sizing and stream constants.
    localparam int MAX_WIDTH   = 4096;
    localparam int STORE_DEPTH = 4 * MAX_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int EXP_OFFSET  = 128 + 8;
    localparam logic [7:0] CODED_FLAG = 8'h80;
    localparam logic [7:0] RUN_BASE   = 8'd128;
    localparam logic [7:0] HDR_MARK   = 8'd2;

    // Result status codes.
    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_PIXEL     = 3'd1;
    localparam logic [2:0] ST_NONE      = 3'd2;
    localparam logic [2:0] ST_REFUSED   = 3'd3;
    localparam logic [2:0] ST_WIDTH_ERR = 3'd4;
    localparam logic [2:0] ST_COUNT_ERR = 3'd5;
    localparam logic [2:0] ST_DONE      = 3'd6;

    // Configuration register indexes.
    localparam logic CFG_LINE_WIDTH   = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // What the latched transaction needs from the controller.
    typedef enum logic [1:0] {
        K_RESULT,
        K_COUNT,
        K_RUN,
        K_PULL
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       latch;
        logic       exec;
        logic       div_init;
        logic       div_step;
        logic       count_fin;
        logic       run_step;
        logic       rd_addr_en;
        logic [1:0] rd_addr_sel;
        logic       rd_cap_en;
        logic [1:0] rd_cap_sel;
        logic       conv;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  can_load;
        logic  run_last;
    } dp_stat_t;

    // Exact IEEE single bits of m * 2^(e - EXP_OFFSET).
    function automatic logic [31:0] to_single(input logic [7:0] m, input logic [7:0] e);
        logic [2:0]  p;
        logic [9:0]  psum;
        logic [31:0] mant;
        logic [31:0] r;
        logic [4:0]  sh;
        p = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (m[i])
                p = i[2:0];
        end
        psum = {7'd0, p} + {2'd0, e};
        mant = {24'd0, m} << (5'd23 - {2'd0, p});
        sh   = e[4:0] + 5'd13;
        if (m == 8'd0)
            r = 32'd0;
        else if (psum >= 10'(EXP_OFFSET - 126))
            r = {1'b0, 8'(psum - 10'(EXP_OFFSET - 127)), mant[22:0]};
        else
            r = {24'd0, m} << sh;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/rrle_if.sv */
// Valid/ready channel interfaces for the decoder's input and result transactions.
`default_nettype none

interface rrle_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] byte_in;

    modport source (output valid, output cmd, output byte_in, input ready);
    modport sink   (input valid, input cmd, input byte_in, output ready);
endinterface

interface rrle_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic        last_pixel;
    logic [2:0]  status;

    modport source (output valid, output red, output green, output blue,
                    output last_pixel, output status, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_pixel, input status, output ready);
endinterface

`default_nettype wire

/* rtl/rgbe_rle_scanline_decoder.sv */
// Top level of the RGBE run-length scanline decoder.
// The in_ch channel carries one transaction per stream byte (cmd 0) or per
// pixel pull (cmd 1); every input transaction produces exactly one result
// transaction on out_ch with three IEEE single colors, last_pixel and status.
// line_width and image_height are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, as the block does not enforce it; both reset to 512.
// How each transaction is handled, from acceptance to result valid:
//   header, literal, refused, error, done, empty-pull and flat-pixel transactions: executed directly;
//   count bytes: through the bit-serial remainder unit (15 steps);
//   run bytes: one store write per cycle, up to 127 writes;
//   stored pixel pulls: four reads of the single store read port, then conversion.
// One transaction is in flight at a time. The result sits in an output
// register; a new transaction is taken while that result waits only if the
// receiver takes it in the same cycle, so a stalled receiver stalls in_ch.
// Reset clears all decoder state and errors; the plane store is not cleared.
// Errors are sticky until reset.
`default_nettype none

module rgbe_rle_scanline_decoder
    import rrle_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [14:0] cfg_data,
    rrle_in_if.sink          in_ch,
    rrle_out_if.source       out_ch
);

    logic [12:0] line_width_reg;
    logic [14:0] image_height_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= 13'd512;
            image_height_reg <= 15'd512;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_LINE_WIDTH)
                line_width_reg <= cfg_data[12:0];
            else if (cfg_index == CFG_IMAGE_HEIGHT)
                image_height_reg <= cfg_data;
        end
    end

    rrle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrle_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_cmd       (in_ch.cmd),
        .in_byte      (in_ch.byte_in),
        .line_width   (line_width_reg),
        .image_height (image_height_reg),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .red          (out_ch.red),
        .green        (out_ch.green),
        .blue         (out_ch.blue),
        .last_pixel   (out_ch.last_pixel),
        .status       (out_ch.status)
    );

    // One transaction in flight: no acceptance right after an acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input accepted twice in a row");

    // Colors are zero unless a pixel is delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status != ST_PIXEL |->
            out_ch.red == 32'd0 && out_ch.green == 32'd0 && out_ch.blue == 32'd0)
        else $error("color on non-pixel result");

    // The final-pixel flag only marks pixels.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.last_pixel |-> out_ch.status == ST_PIXEL)
        else $error("last_pixel on non-pixel result");

    // A new result is produced only while a transaction is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> !$past(in_ch.ready))
        else $error("result without a transaction in flight");

endmodule

`default_nettype wire

/* rtl/rrle_datapath.sv */
// Datapath of the decoder: stream state, plane store, remainder unit and result register.
`default_nettype none

module rrle_datapath
    import rrle_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         stat,
    input  wire logic        in_cmd,
    input  wire logic [7:0]  in_byte,
    input  wire logic [12:0] line_width,
    input  wire logic [14:0] image_height,
    input  wire logic        out_ready,
    output logic             out_valid,
    output logic [31:0]      red,
    output logic [31:0]      green,
    output logic [31:0]      blue,
    output logic             last_pixel,
    output logic [2:0]       status
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_COUNT,
        PH_RUN,
        PH_LITERAL
    } phase_t;

    logic        cmd_reg, cmd_next;
    logic [7:0]  byte_reg, byte_next;
    logic [14:0] fill_reg, fill_next;
    phase_t      phase_reg, phase_next;
    logic [6:0]  run_rem_reg, run_rem_next;
    logic [31:0] hdr_reg, hdr_next;
    logic [1:0]  hidx_reg, hidx_next;
    logic        flat_reg, flat_next;
    logic [14:0] lines_reg, lines_next;
    logic [12:0] drain_reg, drain_next;
    logic [12:0] pend_reg, pend_next;
    logic [2:0]  err_reg, err_next;
    logic [14:0] rem_reg, rem_next;
    logic [14:0] dvd_reg, dvd_next;
    logic [7:0]  pix_reg [4];
    logic [7:0]  pix_next [4];
    logic        out_valid_reg, out_valid_next;
    logic [31:0] red_reg, red_next;
    logic [31:0] green_reg, green_next;
    logic [31:0] blue_reg, blue_next;
    logic        last_reg, last_next;
    logic [2:0]  status_reg, status_next;

    // Plane store with one write and one registered read port.
    logic [7:0]        store_mem [STORE_DEPTH];
    logic [7:0]        mem_q;
    logic              ok_q;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       rd_k;
    logic [15:0]       w1, w2, w3;

    // Shared derived values.
    logic [14:0] fill_inc;
    logic [14:0] width4;
    logic [14:0] width15;
    logic        width_bad;
    logic        image_done;
    logic [12:0] pend_dec;
    logic [12:0] drain_inc;
    logic [31:0] hdr_new;
    logic [14:0] room;
    logic [14:0] div_t;
    logic [7:0]  run_c;
    logic        coded;

    assign fill_inc   = fill_reg + 15'd1;
    assign width4     = {line_width, 2'b00};
    assign width15    = {2'd0, line_width};
    assign width_bad  = (line_width == 13'd0) || (line_width > 13'(MAX_WIDTH));
    assign image_done = lines_reg >= image_height;
    assign pend_dec   = pend_reg - 13'd1;
    assign drain_inc  = drain_reg + 13'd1;
    assign room       = width15 - rem_reg;
    assign run_c      = byte_reg - RUN_BASE;

    // Place the new header byte into its lane; the first byte clears the rest.
    always_comb
    begin
        case (hidx_reg)
            2'd0:    hdr_new = {24'd0, byte_reg};
            2'd1:    hdr_new = {hdr_reg[31:16], byte_reg, hdr_reg[7:0]};
            2'd2:    hdr_new = {hdr_reg[31:24], byte_reg, hdr_reg[15:0]};
            default: hdr_new = {byte_reg, hdr_reg[23:0]};
        endcase
    end

    assign coded = !flat_reg && (hdr_new[7:0] == HDR_MARK) && (hdr_new[15:8] == HDR_MARK)
                   && ((hdr_new[23:16] & CODED_FLAG) == 8'd0);

    // Classify the latched transaction for the controller.
    always_comb
    begin
        stat.kind = K_RESULT;
        if (err_reg == 3'd0)
        begin
            if (!cmd_reg)
            begin
                if (pend_reg == 13'd0 && !image_done && !width_bad)
                begin
                    if (phase_reg == PH_COUNT)
                        stat.kind = K_COUNT;
                    else if (phase_reg == PH_RUN)
                        stat.kind = K_RUN;
                end
            end
            else if (pend_reg != 13'd0 && !flat_reg)
            begin
                stat.kind = K_PULL;
            end
        end
        stat.can_load = !out_valid_reg || out_ready;
        stat.run_last = run_rem_reg == 7'd1;
    end

    // Store read address for the selected plane.
    assign w1 = {3'd0, line_width};
    assign w2 = {2'd0, line_width, 1'b0};
    assign w3 = w1 + w2;
    always_comb
    begin
        case (cmd.rd_addr_sel)
            2'd0:    rd_k = {3'd0, drain_reg};
            2'd1:    rd_k = {3'd0, drain_reg} + w1;
            2'd2:    rd_k = {3'd0, drain_reg} + w2;
            default: rd_k = {3'd0, drain_reg} + w3;
        endcase
    end

    assign div_t = ({rem_reg[13:0], dvd_reg[14]} >= width15)
                   ? {rem_reg[13:0], dvd_reg[14]} - width15
                   : {rem_reg[13:0], dvd_reg[14]};

    // Next-state logic for all commands.
    always_comb
    begin
        cmd_next       = cmd_reg;
        byte_next      = byte_reg;
        fill_next      = fill_reg;
        phase_next     = phase_reg;
        run_rem_next   = run_rem_reg;
        hdr_next       = hdr_reg;
        hidx_next      = hidx_reg;
        flat_next      = flat_reg;
        lines_next     = lines_reg;
        drain_next     = drain_reg;
        pend_next      = pend_reg;
        err_next       = err_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        pix_next       = pix_reg;
        out_valid_next = out_valid_reg && !out_ready;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_waddr      = fill_reg[ADDR_W-1:0];

        if (cmd.latch)
        begin
            cmd_next  = in_cmd;
            byte_next = in_byte;
        end

        // Single-step transactions and the result of any of them.
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
            red_next       = 32'd0;
            green_next     = 32'd0;
            blue_next      = 32'd0;
            last_next      = 1'b0;
            status_next    = ST_ACCEPTED;
            if (err_reg != 3'd0)
            begin
                status_next = err_reg;
            end
            else if (!cmd_reg)
            begin
                if (pend_reg != 13'd0)
                    status_next = ST_REFUSED;
                else if (image_done)
                    status_next = ST_DONE;
                else if (width_bad)
                begin
                    err_next    = ST_WIDTH_ERR;
                    status_next = ST_WIDTH_ERR;
                end
                else if (phase_reg == PH_HEADER)
                begin
                    hdr_next = hdr_new;
                    if (hidx_reg != 2'd3)
                        hidx_next = hidx_reg + 2'd1;
                    else
                    begin
                        hidx_next = 2'd0;
                        if (!coded)
                        begin
                            // Flat pixel: the header word is the pixel itself.
                            flat_next  = 1'b1;
                            pend_next  = 13'd1;
                            drain_next = 13'd0;
                            if (fill_inc >= width15)
                            begin
                                fill_next  = 15'd0;
                                lines_next = lines_reg + 15'd1;
                            end
                            else
                                fill_next = fill_inc;
                        end
                        else if ({hdr_new[23:16], hdr_new[31:24]} != {3'd0, line_width})
                        begin
                            err_next    = ST_WIDTH_ERR;
                            status_next = ST_WIDTH_ERR;
                        end
                        else
                        begin
                            fill_next  = 15'd0;
                            phase_next = PH_COUNT;
                        end
                    end
                end
                else
                begin
                    // Literal byte.
                    mem_we    = !fill_reg[14];
                    fill_next = fill_inc;
                    if (run_rem_reg == 7'd0)
                        phase_next = PH_COUNT;
                    else
                        run_rem_next = run_rem_reg - 7'd1;
                    if (fill_inc >= width4)
                    begin
                        fill_next    = 15'd0;
                        phase_next   = PH_HEADER;
                        run_rem_next = 7'd0;
                        hidx_next    = 2'd0;
                        lines_next   = lines_reg + 15'd1;
                        pend_next    = line_width;
                        drain_next   = 13'd0;
                    end
                end
            end
            else if (pend_reg != 13'd0)
            begin
                // Flat pull straight from the header word.
                red_next    = to_single(hdr_reg[7:0], hdr_reg[31:24]);
                green_next  = to_single(hdr_reg[15:8], hdr_reg[31:24]);
                blue_next   = to_single(hdr_reg[23:16], hdr_reg[31:24]);
                drain_next  = drain_inc;
                pend_next   = pend_dec;
                last_next   = (pend_dec == 13'd0) && image_done;
                status_next = ST_PIXEL;
            end
            else if (image_done)
                status_next = ST_DONE;
            else
                status_next = ST_NONE;
        end

        // Remainder of the fill position by the line width, one bit a cycle.
        if (cmd.div_init)
        begin
            rem_next = 15'd0;
            dvd_next = fill_reg;
        end
        if (cmd.div_step)
        begin
            rem_next = div_t;
            dvd_next = {dvd_reg[13:0], 1'b0};
        end

        // Count byte against the room left in the plane.
        if (cmd.count_fin)
        begin
            out_valid_next = 1'b1;
            red_next       = 32'd0;
            green_next     = 32'd0;
            blue_next      = 32'd0;
            last_next      = 1'b0;
            status_next    = ST_ACCEPTED;
            if (byte_reg > RUN_BASE)
            begin
                if ({7'd0, run_c} > room)
                begin
                    err_next    = ST_COUNT_ERR;
                    status_next = ST_COUNT_ERR;
                end
                else
                begin
                    run_rem_next = run_c[6:0];
                    phase_next   = PH_RUN;
                end
            end
            else if (byte_reg == 8'd0 || {7'd0, byte_reg} > room)
            begin
                err_next    = ST_COUNT_ERR;
                status_next = ST_COUNT_ERR;
            end
            else
            begin
                run_rem_next = 7'(byte_reg - 8'd1);
                phase_next   = PH_LITERAL;
            end
        end

        // One run byte into the store per cycle.
        if (cmd.run_step)
        begin
            mem_we       = !fill_reg[14];
            fill_next    = fill_inc;
            run_rem_next = run_rem_reg - 7'd1;
            if (run_rem_reg == 7'd1)
            begin
                phase_next     = PH_COUNT;
                out_valid_next = 1'b1;
                red_next       = 32'd0;
                green_next     = 32'd0;
                blue_next      = 32'd0;
                last_next      = 1'b0;
                status_next    = ST_ACCEPTED;
                if (fill_inc >= width4)
                begin
                    fill_next    = 15'd0;
                    phase_next   = PH_HEADER;
                    run_rem_next = 7'd0;
                    hidx_next    = 2'd0;
                    lines_next   = lines_reg + 15'd1;
                    pend_next    = line_width;
                    drain_next   = 13'd0;
                end
            end
        end

        if (cmd.rd_cap_en)
            pix_next[cmd.rd_cap_sel] = ok_q ? mem_q : 8'd0;

        // Convert the gathered planes of a stored pixel.
        if (cmd.conv)
        begin
            out_valid_next = 1'b1;
            red_next       = to_single(pix_reg[0], pix_reg[3]);
            green_next     = to_single(pix_reg[1], pix_reg[3]);
            blue_next      = to_single(pix_reg[2], pix_reg[3]);
            drain_next     = drain_inc;
            pend_next      = pend_dec;
            last_next      = (pend_dec == 13'd0) && image_done;
            status_next    = ST_PIXEL;
        end
    end

    // Plane store.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= byte_reg;
        if (cmd.rd_addr_en)
        begin
            mem_q <= store_mem[rd_k[ADDR_W-1:0]];
            ok_q  <= rd_k < 16'(STORE_DEPTH);
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        byte_reg   <= byte_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        pix_reg    <= pix_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    // Decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= 15'd0;
            phase_reg     <= PH_HEADER;
            run_rem_reg   <= 7'd0;
            hdr_reg       <= 32'd0;
            hidx_reg      <= 2'd0;
            flat_reg      <= 1'b0;
            lines_reg     <= 15'd0;
            drain_reg     <= 13'd0;
            pend_reg      <= 13'd0;
            err_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            run_rem_reg   <= run_rem_next;
            hdr_reg       <= hdr_next;
            hidx_reg      <= hidx_next;
            flat_reg      <= flat_next;
            lines_reg     <= lines_next;
            drain_reg     <= drain_next;
            pend_reg      <= pend_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign last_pixel = last_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

/* rtl/rrle_ctrl.sv */
// Controller state machine that sequences each transaction through the datapath.
`default_nettype none

module rrle_ctrl
    import rrle_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_CFIN,
        S_RUN,
        S_READ,
        S_CONV
    } state_t;

    localparam logic [3:0] DIV_LAST = 4'd14;
    localparam logic [3:0] RD_LAST  = 4'd4;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == S_IDLE) && stat.can_load;

    // Command decode and next state.
    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cnt_next = 4'd0;
                case (stat.kind)
                    K_COUNT:
                    begin
                        cmd.div_init = 1'b1;
                        state_next   = S_DIV;
                    end
                    K_RUN:   state_next = S_RUN;
                    K_PULL:  state_next = S_READ;
                    default:
                    begin
                        cmd.exec   = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_CFIN;
            end
            S_CFIN:
            begin
                cmd.count_fin = 1'b1;
                state_next    = S_IDLE;
            end
            S_RUN:
            begin
                cmd.run_step = 1'b1;
                if (stat.run_last)
                    state_next = S_IDLE;
            end
            S_READ:
            begin
                // Address plane n while capturing plane n-1.
                cmd.rd_addr_en  = cnt_reg != RD_LAST;
                cmd.rd_addr_sel = cnt_reg[1:0];
                cmd.rd_cap_en   = cnt_reg != 4'd0;
                cmd.rd_cap_sel  = 2'(cnt_reg - 4'd1);
                cnt_next        = cnt_reg + 4'd1;
                if (cnt_reg == RD_LAST)
                    state_next = S_CONV;
            end
            S_CONV:
            begin
                cmd.conv   = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire
